// ----- rtl/npmac_pkg.sv -----
package npmac_pkg;

   localparam int POS_W  = 5;
   localparam int COEF_W = 32;
   localparam int ACC_W  = 64;
   // the rotating store holds +/- b, and -(-2^31) needs one more bit
   localparam int CELL_W = COEF_W + 1;
   localparam int PROD_W = CELL_W + COEF_W;
   localparam int MAX_RUN = 32;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_MAC  = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   typedef struct packed {
      logic [1:0]                operation;
      logic [POS_W-1:0]          position;
      logic signed [COEF_W-1:0]  coefficient;
      logic                      clear_first;
   } req_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] result_value;
      logic [POS_W-1:0]        result_index;
      logic                    last_of_run;
   } rsp_type;

   typedef struct packed {
      logic                      shift_b;
      logic                      mul_en;
      logic                      acc_en;
      logic                      acc_clear;
      logic                      acc_sub;
      logic                      rot_acc;
      logic signed [COEF_W-1:0]  coef;
      logic signed [CELL_W-1:0]  b_wr_value;
   } cell_ctrl_type;

endpackage

// ----- rtl/npmac_cell.sv -----
module npmac_cell (
   input  logic                                   clock,
   input  logic                                   reset,
   input  npmac_pkg::cell_ctrl_type               ctrl,
   input  logic                                   wr_sel,
   input  logic signed [npmac_pkg::CELL_W-1:0]    b_prev,
   input  logic signed [npmac_pkg::ACC_W-1:0]     acc_next,
   output logic signed [npmac_pkg::CELL_W-1:0]    b_out,
   output logic signed [npmac_pkg::ACC_W-1:0]     acc_out
);

   logic signed [npmac_pkg::CELL_W-1:0] b_ff;
   logic signed [npmac_pkg::ACC_W-1:0]  acc_ff;
   logic signed [npmac_pkg::ACC_W-1:0]  acc_in;
   logic signed [npmac_pkg::ACC_W-1:0]  acc_base;
   logic signed [npmac_pkg::ACC_W-1:0]  prod_ff;
   logic signed [npmac_pkg::PROD_W-1:0] prod_full;

   assign prod_full = b_ff * ctrl.coef;

   always_comb begin
      acc_base = ctrl.acc_clear ? '0 : acc_ff;
      // wrapped orientation of the ring turns the product into a subtraction
      acc_in   = ctrl.acc_sub ? (acc_base - prod_ff) : (acc_base + prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ff   <= '0;
         acc_ff <= '0;
      end else begin
         if (wr_sel) begin
            b_ff <= ctrl.b_wr_value;
         end else if (ctrl.shift_b) begin
            b_ff <= b_prev;
         end
         if (ctrl.acc_en) begin
            acc_ff <= acc_in;
         end else if (ctrl.rot_acc) begin
            acc_ff <= acc_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= prod_full[npmac_pkg::ACC_W-1:0];
      end
   end

   assign b_out   = b_ff;
   assign acc_out = acc_ff;

endmodule

// ----- rtl/negacyclic_poly_multiply_accumulate_core.sv -----
// Negacyclic multiply-accumulate over a ring of RING_DEGREE cells. Each cell holds one
// accumulator and one coefficient of the second polynomial; the coefficients rotate
// as x*b mod x^M+1 (the value leaving the top cell re-enters the bottom negated), so
// a multiply at position i waits until the ring holds +/- x^i*b and then every cell
// multiplies and accumulates in parallel. One transaction at a time is in work:
// a load writes its cell in ST_SEEK; a multiply shifts the ring in ST_SEEK by 0 to
// RING_DEGREE-1 places (the distance from the ring's current rotation to the requested
// position), then passes ST_MUL and ST_ACC; a read circulates the accumulators past
// cell 0 in ST_READ, holding while the result side stalls. The first
// min(RING_DEGREE, 32) accumulators of a read are delivered through an output register,
// so the block is ready for the next request while the last result still waits.
module negacyclic_poly_multiply_accumulate_core #(
   parameter int RING_DEGREE = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  npmac_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output npmac_pkg::rsp_type  rsp_data
);

   localparam int IDX_W = $clog2(RING_DEGREE);
   localparam int CW    = (IDX_W + 1 > npmac_pkg::POS_W) ? IDX_W + 1 : npmac_pkg::POS_W;
   localparam int N_OUT = (RING_DEGREE < npmac_pkg::MAX_RUN) ? RING_DEGREE
                                                              : npmac_pkg::MAX_RUN;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEEK,
      ST_MUL,
      ST_ACC,
      ST_READ
   } state_type;

   state_type               state_ff, state_in;
   npmac_pkg::req_type      req_ff, req_in;
   logic [IDX_W-1:0]        r_idx_ff, r_idx_in;
   logic                    r_neg_ff, r_neg_in;
   logic [IDX_W-1:0]        k_ff, k_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   npmac_pkg::rsp_type      rsp_data_ff, rsp_data_in;

   npmac_pkg::cell_ctrl_type ctrl;
   logic                     wr_en;
   logic [RING_DEGREE-1:0]   wr_sel;
   logic                     pos_ok;
   logic [IDX_W-1:0]         pos_idx;
   logic [CW-1:0]            wsum;
   logic                     wwrap;
   logic [IDX_W-1:0]         wr_idx;
   logic                     wr_neg;
   logic signed [npmac_pkg::CELL_W-1:0] coef_ext;
   logic                     out_free;

   logic signed [npmac_pkg::CELL_W-1:0] b_chain   [RING_DEGREE];
   logic signed [npmac_pkg::ACC_W-1:0]  acc_chain [RING_DEGREE];
   logic signed [npmac_pkg::CELL_W-1:0] b_wrap;

   assign pos_ok  = CW'(req_ff.position) < CW'(RING_DEGREE);
   assign pos_idx = IDX_W'(req_ff.position);

   // cell that currently holds b[position], and its sign under the present rotation
   assign wsum   = CW'(req_ff.position) + CW'(r_idx_ff);
   assign wwrap  = wsum >= CW'(RING_DEGREE);
   assign wr_idx = wwrap ? IDX_W'(wsum - CW'(RING_DEGREE)) : IDX_W'(wsum);
   assign wr_neg = wwrap ^ r_neg_ff;
   assign coef_ext = {req_ff.coefficient[npmac_pkg::COEF_W-1], req_ff.coefficient};

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      r_idx_in     = r_idx_ff;
      r_neg_in     = r_neg_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;

      ctrl            = '0;
      ctrl.coef       = req_ff.coefficient;
      ctrl.acc_clear  = req_ff.clear_first;
      ctrl.acc_sub    = r_neg_ff;
      ctrl.b_wr_value = wr_neg ? -coef_ext : coef_ext;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = ST_SEEK;
            end
         end
         ST_SEEK: begin
            priority if (req_ff.operation == npmac_pkg::OP_LOAD) begin
               wr_en    = pos_ok;
               state_in = ST_IDLE;
            end else if (req_ff.operation == npmac_pkg::OP_MAC) begin
               if (!pos_ok) begin
                  state_in = ST_IDLE;
               end else if (r_idx_ff == pos_idx) begin
                  state_in = ST_MUL;
               end else begin
                  ctrl.shift_b = 1'b1;
                  if (r_idx_ff == IDX_W'(RING_DEGREE - 1)) begin
                     r_idx_in = '0;
                     r_neg_in = !r_neg_ff;
                  end else begin
                     r_idx_in = r_idx_ff + 1'b1;
                  end
               end
            end else if (req_ff.operation == npmac_pkg::OP_READ) begin
               k_in     = '0;
               state_in = ST_READ;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MUL: begin
            ctrl.mul_en = 1'b1;
            state_in    = ST_ACC;
         end
         ST_ACC: begin
            ctrl.acc_en = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_READ: begin
            // beyond the delivered run the ring keeps turning to restore its order
            if ((32'(k_ff) >= N_OUT) || out_free) begin
               ctrl.rot_acc = 1'b1;
               if (32'(k_ff) < N_OUT) begin
                  rsp_valid_in              = 1'b1;
                  rsp_data_in.result_value  = acc_chain[0];
                  rsp_data_in.result_index  = npmac_pkg::POS_W'(k_ff);
                  rsp_data_in.last_of_run   = (32'(k_ff) == N_OUT - 1);
               end
               if (k_ff == IDX_W'(RING_DEGREE - 1)) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         r_idx_ff     <= '0;
         r_neg_ff     <= 1'b0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         r_idx_ff     <= r_idx_in;
         r_neg_ff     <= r_neg_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign b_wrap = -b_chain[RING_DEGREE-1];

   for (genvar g = 0; g < RING_DEGREE; g++) begin : g_cell
      logic signed [npmac_pkg::CELL_W-1:0] b_prev;

      assign wr_sel[g] = wr_en && (wr_idx == IDX_W'(g));

      if (g == 0) begin : g_first
         assign b_prev = b_wrap;
      end else begin : g_rest
         assign b_prev = b_chain[g-1];
      end

      npmac_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .wr_sel   (wr_sel[g]),
         .b_prev   (b_prev),
         .acc_next (acc_chain[(g + 1) % RING_DEGREE]),
         .b_out    (b_chain[g]),
         .acc_out  (acc_chain[g])
      );
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
